@@ rtl/scpfa_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// scpfa_pkg: shared types and constants
// Register map, config bundle, the pair word passed from front to back and
// the state types of both sequencers.
// ----------------------------------------------------------------------------
package scpfa_pkg;

    localparam int unsigned POS_W         = 32;
    localparam int unsigned LEN_W         = 31;
    localparam int unsigned FRC_W         = 48;
    localparam int unsigned ENG_W         = 40;
    localparam int unsigned OVL_W         = 16;
    localparam int unsigned CFG_IDX_W     = 3;
    localparam int unsigned CFG_DATA_W    = 32;
    localparam int unsigned MUL_W         = 32;
    localparam int unsigned QDEPTH        = 2;
    localparam int unsigned FRAC_BITS_DEF = 16;

    localparam logic [LEN_W-1:0] RST_CUTOFF = 31'd131072;
    localparam logic [LEN_W-1:0] RST_WELL   = 31'd524288;
    localparam logic [LEN_W-1:0] RST_SCALE  = 31'd65536;
    localparam logic [LEN_W-1:0] RST_BOX    = 31'd4194304;

    localparam logic [FRC_W-1:0] FRC_CAP = '1;
    localparam logic [ENG_W-1:0] ENG_MAX = '1;
    localparam logic [OVL_W-1:0] OVL_MAX = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CUTOFF,
        CFG_WELL,
        CFG_SCALE,
        CFG_PERIODIC,
        CFG_BOX_X,
        CFG_BOX_Y,
        CFG_BOX_Z,
        CFG_FORCES
    } t_cfg_idx;

    typedef struct packed {
        logic [LEN_W-1:0]        cutoff;
        logic [LEN_W-1:0]        well;
        logic [LEN_W-1:0]        scale;
        logic                    periodic;
        logic [2:0][LEN_W-1:0]   box;
        logic                    forces_en;
    } t_cfg;

    // one pair after wrap and per-axis cutoff screening
    typedef struct packed {
        logic [2:0][LEN_W-1:0]   mag;
        logic [2:0]              neg;
        logic                    act;
        logic                    last;
    } t_pair;

    typedef enum logic [1:0] {
        F_IDLE,
        F_WRAP,
        F_CLASS
    } t_fstate;

    typedef enum logic [4:0] {
        B_IDLE,
        B_R0,
        B_R1,
        B_R2,
        B_R3,
        B_CUT,
        B_SQRT,
        B_DU,
        B_DUW,
        B_U2,
        B_U3,
        B_E,
        B_EA,
        B_FM,
        B_DGW,
        B_GL,
        B_GH,
        B_M,
        B_CD,
        B_CDW,
        B_CL,
        B_CH,
        B_CA,
        B_CF,
        B_FIN
    } t_bstate;

endpackage
`default_nettype wire

@@ rtl/scpfa_regs.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// scpfa_regs: configuration register file
// Always ready; one register per write word.
// ----------------------------------------------------------------------------
module scpfa_regs (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_valid,
    input  wire logic [scpfa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [scpfa_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                                  o_cfg_ready,
    output scpfa_pkg::t_cfg                       o_cfg
);
    import scpfa_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cutoff    <= RST_CUTOFF;
            r_cfg.well      <= RST_WELL;
            r_cfg.scale     <= RST_SCALE;
            r_cfg.periodic  <= 1'b0;
            r_cfg.box[0]    <= RST_BOX;
            r_cfg.box[1]    <= RST_BOX;
            r_cfg.box[2]    <= RST_BOX;
            r_cfg.forces_en <= 1'b1;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_CUTOFF:   r_cfg.cutoff    <= i_cfg_data[LEN_W-1:0];
                CFG_WELL:     r_cfg.well      <= i_cfg_data[LEN_W-1:0];
                CFG_SCALE:    r_cfg.scale     <= i_cfg_data[LEN_W-1:0];
                CFG_PERIODIC: r_cfg.periodic  <= i_cfg_data[0];
                CFG_BOX_X:    r_cfg.box[0]    <= i_cfg_data[LEN_W-1:0];
                CFG_BOX_Y:    r_cfg.box[1]    <= i_cfg_data[LEN_W-1:0];
                CFG_BOX_Z:    r_cfg.box[2]    <= i_cfg_data[LEN_W-1:0];
                CFG_FORCES:   r_cfg.forces_en <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

@@ rtl/scpfa_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// scpfa_front: pair intake
// Forms the separation, applies one minimum-image step per axis when periodic,
// screens each axis against the cutoff, hands the pair word to the queue.
// ----------------------------------------------------------------------------
module scpfa_front (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  scpfa_pkg::t_cfg                           i_cfg,
    input  wire logic                                 i_push,
    input  wire logic [2:0][scpfa_pkg::POS_W-1:0]     i_ref,
    input  wire logic [2:0][scpfa_pkg::POS_W-1:0]     i_other,
    input  wire logic                                 i_pair_counts,
    input  wire logic                                 i_last_pair,
    output logic                                      o_full,
    input  wire logic                                 i_q_full,
    output logic                                      o_q_push,
    output scpfa_pkg::t_pair                          o_q_data
);
    import scpfa_pkg::*;

    t_fstate r_state, n_state;

    logic signed [POS_W:0]   r_d [3];
    logic signed [POS_W+1:0] r_w [3];
    logic                    r_act;
    logic                    r_last;

    logic signed [POS_W+1:0] dx  [3];
    logic        [POS_W+1:0] da  [3];
    logic signed [POS_W+1:0] wv  [3];
    logic        [POS_W+1:0] wm  [3];
    logic        [2:0]       outr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE:  if (i_push) n_state = F_WRAP;
            F_WRAP:  n_state = F_CLASS;
            F_CLASS: if (!i_q_full) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_comb begin
        o_full   = 1'b1;
        o_q_push = 1'b0;
        case (r_state)
            F_IDLE:  o_full = 1'b0;
            F_WRAP:  ;
            F_CLASS: o_q_push = !i_q_full;
            default: ;
        endcase
    end

    // wrap and classification datapath
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            dx[k] = (POS_W+2)'(r_d[k]);
            da[k] = dx[k][POS_W+1] ? (POS_W+2)'(-dx[k]) : dx[k];
            wv[k] = dx[k];
            if (i_cfg.periodic && ({da[k], 1'b0} > (POS_W+3)'(i_cfg.box[k]))) begin
                wv[k] = dx[k][POS_W+1] ? dx[k] + $signed((POS_W+2)'(i_cfg.box[k]))
                                       : dx[k] - $signed((POS_W+2)'(i_cfg.box[k]));
            end
            wm[k]   = r_w[k][POS_W+1] ? (POS_W+2)'(-r_w[k]) : r_w[k];
            outr[k] = wm[k] >= (POS_W+2)'(i_cfg.cutoff);
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            o_q_data.mag[k] = wm[k][LEN_W-1:0];
            o_q_data.neg[k] = r_w[k][POS_W+1];
        end
        o_q_data.act  = r_act && (outr == 3'b000);
        o_q_data.last = r_last;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE && i_push) begin
            for (int k = 0; k < 3; k++) begin
                r_d[k] <= $signed({i_ref[k][POS_W-1], i_ref[k]})
                        - $signed({i_other[k][POS_W-1], i_other[k]});
            end
            r_act  <= i_pair_counts;
            r_last <= i_last_pair;
        end
        if (r_state == F_WRAP) begin
            for (int k = 0; k < 3; k++) r_w[k] <= wv[k];
        end
    end

endmodule
`default_nettype wire

@@ rtl/scpfa_fifo.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// scpfa_fifo: pair queue
// Short register queue between intake and the arithmetic sequencer.
// ----------------------------------------------------------------------------
module scpfa_fifo (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    input  scpfa_pkg::t_pair i_data,
    output logic             o_full,
    input  wire logic        i_pop,
    output logic             o_empty,
    output scpfa_pkg::t_pair o_data
);
    import scpfa_pkg::*;

    localparam int unsigned PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int unsigned CW = $clog2(QDEPTH + 1);

    t_pair           r_mem [QDEPTH];
    logic [PW-1:0]   r_wp, r_rp;
    logic [CW-1:0]   r_cnt;
    logic            do_push, do_pop;

    assign o_full  = r_cnt == CW'(QDEPTH);
    assign o_empty = r_cnt == '0;
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= (r_wp == PW'(QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            if (do_pop)  r_rp <= (r_rp == PW'(QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            if (do_push && !do_pop) r_cnt <= r_cnt + 1'b1;
            else if (do_pop && !do_push) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_data;
    end

endmodule
`default_nettype wire

@@ rtl/scpfa_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// scpfa_div: restoring divider, one quotient bit per cycle
// Remainder may be preloaded (must be below the divisor); the quotient bit
// count comes with each start, so short quotients run only over their bits.
// ----------------------------------------------------------------------------
module scpfa_div #(
    parameter int unsigned QW = 49,
    parameter int unsigned CW = 6
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [scpfa_pkg::LEN_W-1:0]   i_den,
    input  wire logic [scpfa_pkg::LEN_W-1:0]   i_rem0,
    input  wire logic [QW-1:0]                 i_num,
    input  wire logic [CW-1:0]                 i_cnt,
    output logic                               o_done,
    output logic [QW-1:0]                      o_quot
);
    import scpfa_pkg::*;

    logic [LEN_W-1:0] r_den, r_rem;
    logic [QW-1:0]    r_qn;
    logic [CW-1:0]    r_cnt;
    logic             r_busy, r_done;
    logic [LEN_W:0]   trial;
    logic             ge;

    assign trial  = {r_rem, r_qn[QW-1]};
    assign ge     = trial >= {1'b0, r_den};
    assign o_done = r_done;
    assign o_quot = r_qn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            r_rem <= i_rem0;
            r_qn  <= i_num;
            r_cnt <= i_cnt;
        end else if (r_busy) begin
            r_rem <= ge ? LEN_W'(trial - {1'b0, r_den}) : trial[LEN_W-1:0];
            r_qn  <= {r_qn[QW-2:0], ge};
            r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule
`default_nettype wire

@@ rtl/scpfa_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// scpfa_back: pair arithmetic sequencer
// Distance, square root, soft-core energy and optional force over one shared
// 32x32 multiplier and one divider; holds the sums and the result word.
// ----------------------------------------------------------------------------
module scpfa_back #(
    parameter int unsigned FRAC_BITS = scpfa_pkg::FRAC_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  scpfa_pkg::t_cfg                       i_cfg,
    input  wire logic                             i_q_empty,
    input  scpfa_pkg::t_pair                      i_q_data,
    output logic                                  o_q_pop,
    output logic                                  o_empty,
    input  wire logic                             i_pop,
    output logic [2:0][scpfa_pkg::FRC_W-1:0]      o_force,
    output logic [scpfa_pkg::ENG_W-1:0]           o_energy,
    output logic [scpfa_pkg::OVL_W-1:0]           o_overlap
);
    import scpfa_pkg::*;

    localparam int unsigned FW = FRAC_BITS;
    localparam int unsigned QW = 33 + FW;
    localparam int unsigned CW = $clog2(QW + 1);
    localparam logic signed [FRC_W+1:0] FS_MAX = {3'b000, {(FRC_W-1){1'b1}}};
    localparam logic signed [FRC_W+1:0] FS_MIN = {3'b111, {(FRC_W-1){1'b0}}};

    t_bstate r_state, n_state;

    // datapath registers
    t_pair                r_pair;
    logic [63:0]          r_p, r_pl, r_r2, r_sv, r_res, r_bit;
    logic [FW-1:0]        r_u, r_u2;
    logic [FRC_W-1:0]     r_g, r_m, r_comp;
    logic [FW:0]          r_c;
    logic [1:0]           r_ax;
    logic signed [FRC_W-1:0] r_fx [3];
    logic [ENG_W-1:0]     r_energy;
    logic [OVL_W-1:0]     r_ovl;
    logic                 r_res_valid;
    logic [2:0][FRC_W-1:0] r_out_f;
    logic [ENG_W-1:0]     r_out_e;
    logic [OVL_W-1:0]     r_out_o;

    // control
    logic [MUL_W-1:0]     mul_a, mul_b;
    logic                 div_start, div_done, res_load;
    logic [LEN_W-1:0]     div_rem0;
    logic [QW-1:0]        div_num, div_quot;
    logic [CW-1:0]        div_cnt;

    // datapath combinational
    logic [LEN_W-1:0]     r_root, mag_ax;
    logic [63:0]          sq_sum, p3;
    logic                 sq_ge, cut_out, overlap;
    logic [32:0]          fm;
    logic [FRC_W-1:0]     g_cap, m_cap, c_cap;
    logic [79:0]          m_full, m_sh, c_full, c_sh;
    logic [ENG_W:0]       e_sum;
    logic [LEN_W-1:0]     e_in;
    logic                 e_en;
    logic signed [FRC_W+1:0] f_ext, f_sum;
    logic [FRC_W-1:0]     f_new;

    scpfa_div #(.QW(QW), .CW(CW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_den   (r_state == B_DU || r_state == B_FM ? i_cfg.cutoff : r_root),
        .i_rem0  (div_rem0),
        .i_num   (div_num),
        .i_cnt   (div_cnt),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign r_root  = r_res[LEN_W-1:0];
    assign mag_ax  = r_pair.mag[r_ax];
    assign sq_sum  = r_res + r_bit;
    assign sq_ge   = r_sv >= sq_sum;
    assign cut_out = r_r2 >= r_p;
    assign overlap = !cut_out && r_r2 == '0;
    assign p3      = r_p + {r_p[62:0], 1'b0};
    assign fm      = 33'(p3 >> FW);
    assign g_cap   = ((div_quot >> FRC_W) != '0) ? FRC_CAP : FRC_W'(div_quot);
    assign m_full  = ({16'b0, r_p} << 32) + {16'b0, r_pl};
    assign m_sh    = m_full >> FW;
    assign m_cap   = ((m_sh >> FRC_W) != '0) ? FRC_CAP : m_sh[FRC_W-1:0];
    assign c_full  = ({16'b0, r_p} << 24) + {16'b0, r_pl};
    assign c_sh    = c_full >> FW;
    assign c_cap   = ((c_sh >> FRC_W) != '0) ? FRC_CAP : c_sh[FRC_W-1:0];

    assign o_empty   = !r_res_valid;
    assign o_force   = r_out_f;
    assign o_energy  = r_out_e;
    assign o_overlap = r_out_o;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE:  if (!i_q_empty) n_state = i_q_data.act ? B_R0 : B_FIN;
            B_R0:    n_state = B_R1;
            B_R1:    n_state = B_R2;
            B_R2:    n_state = B_R3;
            B_R3:    n_state = B_CUT;
            B_CUT:   n_state = (cut_out || overlap) ? B_FIN : B_SQRT;
            B_SQRT:  if (r_bit[0]) n_state = B_DU;
            B_DU:    n_state = B_DUW;
            B_DUW:   if (div_done) n_state = B_U2;
            B_U2:    n_state = B_U3;
            B_U3:    n_state = B_E;
            B_E:     n_state = B_EA;
            B_EA:    n_state = i_cfg.forces_en ? B_FM : B_FIN;
            B_FM:    n_state = B_DGW;
            B_DGW:   if (div_done) n_state = B_GL;
            B_GL:    n_state = B_GH;
            B_GH:    n_state = B_M;
            B_M:     n_state = B_CD;
            B_CD:    n_state = (mag_ax == r_root) ? B_CL : B_CDW;
            B_CDW:   if (div_done) n_state = B_CL;
            B_CL:    n_state = B_CH;
            B_CH:    n_state = B_CA;
            B_CA:    n_state = B_CF;
            B_CF:    n_state = (r_ax == 2'd2) ? B_FIN : B_CD;
            B_FIN:   if (!r_pair.last || !r_res_valid) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop   = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        div_rem0  = '0;
        div_num   = '0;
        div_cnt   = CW'(FW);
        res_load  = 1'b0;
        case (r_state)
            B_IDLE: o_q_pop = !i_q_empty;
            B_R0: begin
                mul_a = MUL_W'(r_pair.mag[0]);
                mul_b = MUL_W'(r_pair.mag[0]);
            end
            B_R1: begin
                mul_a = MUL_W'(r_pair.mag[1]);
                mul_b = MUL_W'(r_pair.mag[1]);
            end
            B_R2: begin
                mul_a = MUL_W'(r_pair.mag[2]);
                mul_b = MUL_W'(r_pair.mag[2]);
            end
            B_R3: begin
                mul_a = MUL_W'(i_cfg.cutoff);
                mul_b = MUL_W'(i_cfg.cutoff);
            end
            B_DU: begin
                div_start = 1'b1;
                div_rem0  = i_cfg.cutoff - r_root;
            end
            B_U2: begin
                mul_a = MUL_W'(r_u);
                mul_b = MUL_W'(r_u);
            end
            B_U3: begin
                mul_a = MUL_W'(FW'(r_p >> FW));
                mul_b = MUL_W'(r_u);
            end
            B_E: begin
                mul_a = MUL_W'(i_cfg.well);
                mul_b = MUL_W'(FW'(r_p >> FW));
            end
            B_EA: begin
                mul_a = MUL_W'(i_cfg.well);
                mul_b = MUL_W'(r_u2);
            end
            B_FM: begin
                div_start = 1'b1;
                div_num   = QW'(fm) << FW;
                div_cnt   = CW'(QW);
            end
            B_GL: begin
                mul_a = r_g[31:0];
                mul_b = MUL_W'(i_cfg.scale);
            end
            B_GH: begin
                mul_a = MUL_W'(r_g[FRC_W-1:32]);
                mul_b = MUL_W'(i_cfg.scale);
            end
            B_CD: begin
                div_start = mag_ax != r_root;
                div_rem0  = mag_ax;
            end
            B_CL: begin
                mul_a = MUL_W'(r_m[23:0]);
                mul_b = MUL_W'(r_c);
            end
            B_CH: begin
                mul_a = MUL_W'(r_m[FRC_W-1:24]);
                mul_b = MUL_W'(r_c);
            end
            B_FIN: res_load = r_pair.last && !r_res_valid;
            default: ;
        endcase
    end

    // shared multiplier, product registered in the cycle after the operands
    always_ff @(posedge i_clk) begin
        r_p <= {32'b0, mul_a} * {32'b0, mul_b};
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: if (!i_q_empty) r_pair <= i_q_data;
            B_R1:   r_r2 <= r_p;
            B_R2:   r_r2 <= r_r2 + r_p;
            B_R3:   r_r2 <= r_r2 + r_p;
            B_CUT: begin
                r_sv  <= r_r2;
                r_res <= '0;
                r_bit <= 64'h4000_0000_0000_0000;
            end
            B_SQRT: begin
                if (sq_ge) begin
                    r_sv  <= r_sv - sq_sum;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            B_DUW:  if (div_done) r_u <= div_quot[FW-1:0];
            B_U3:   r_u2 <= FW'(r_p >> FW);
            B_DGW:  if (div_done) r_g <= g_cap;
            B_GH:   r_pl <= r_p;
            B_M: begin
                r_m  <= m_cap;
                r_ax <= 2'd0;
            end
            B_CD:   if (mag_ax == r_root) r_c <= (FW+1)'(1) << FW;
            B_CDW:  if (div_done) r_c <= div_quot[FW:0];
            B_CH:   r_pl <= r_p;
            B_CA:   r_comp <= c_cap;
            B_CF:   r_ax <= r_ax + 2'd1;
            default: ;
        endcase
    end

    // sums
    always_comb begin
        e_en = 1'b0;
        e_in = i_cfg.well;
        if (r_state == B_CUT) begin
            e_en = overlap;
        end else if (r_state == B_EA) begin
            e_en = 1'b1;
            e_in = LEN_W'(r_p >> FW);
        end
        e_sum = {1'b0, r_energy} + (ENG_W+1)'(e_in);
        f_ext = $signed({2'b00, r_comp});
        f_sum = (FRC_W+2)'(r_fx[r_ax]) + (r_pair.neg[r_ax] ? -f_ext : f_ext);
        if (f_sum > FS_MAX)      f_new = FS_MAX[FRC_W-1:0];
        else if (f_sum < FS_MIN) f_new = FS_MIN[FRC_W-1:0];
        else                     f_new = f_sum[FRC_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) r_fx[k] <= '0;
            r_energy    <= '0;
            r_ovl       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (e_en) r_energy <= e_sum[ENG_W] ? ENG_MAX : e_sum[ENG_W-1:0];
            if (r_state == B_CUT && overlap && r_ovl != OVL_MAX) r_ovl <= r_ovl + 1'b1;
            if (r_state == B_CF) r_fx[r_ax] <= f_new;
            if (res_load) begin
                for (int k = 0; k < 3; k++) r_fx[k] <= '0;
                r_energy    <= '0;
                r_ovl       <= '0;
                r_res_valid <= 1'b1;
            end else if (i_pop) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            for (int k = 0; k < 3; k++) r_out_f[k] <= r_fx[k];
            r_out_e <= r_energy;
            r_out_o <= r_ovl;
        end
    end

endmodule
`default_nettype wire

@@ rtl/soft_core_pair_force_accumulator.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// soft_core_pair_force_accumulator: soft-core repulsion pair accumulator
// Sums cubic soft-sphere energy and force over a stream of neighbour pairs
// and emits the totals on each last pair.
// ----------------------------------------------------------------------------
//  channel   | handshake               | content
//  ----------+-------------------------+--------------------------------------
//  input     | push / full             | two positions, pair_counts, last_pair
//  result    | empty / pop             | force x/y/z, energy sum, overlap count
//  config    | i_cfg_valid/o_cfg_ready | register index and data word
//
//  Intake passes each word through wrap and screening states into a 2-entry
//  queue, taking a new word only once the last one is queued. The back end
//  ends skipped, cutoff and overlap pairs early; the rest are paced by the
//  bit-serial square root and the shared one-bit-per-cycle divider.
//  Synchronous active-low reset clears sums, queue and sequencers.
//  A held result stalls the back end at the next last pair; the queue and
//  then the intake back up behind it.
// ----------------------------------------------------------------------------
module soft_core_pair_force_accumulator #(
    parameter int unsigned FRAC_BITS = scpfa_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 push,
    output logic                                      full,
    input  wire logic [scpfa_pkg::POS_W-1:0]          i_ref_x,
    input  wire logic [scpfa_pkg::POS_W-1:0]          i_ref_y,
    input  wire logic [scpfa_pkg::POS_W-1:0]          i_ref_z,
    input  wire logic [scpfa_pkg::POS_W-1:0]          i_other_x,
    input  wire logic [scpfa_pkg::POS_W-1:0]          i_other_y,
    input  wire logic [scpfa_pkg::POS_W-1:0]          i_other_z,
    input  wire logic                                 i_pair_counts,
    input  wire logic                                 i_last_pair,
    output logic                                      empty,
    input  wire logic                                 pop,
    output logic [scpfa_pkg::FRC_W-1:0]               o_force_x,
    output logic [scpfa_pkg::FRC_W-1:0]               o_force_y,
    output logic [scpfa_pkg::FRC_W-1:0]               o_force_z,
    output logic [scpfa_pkg::ENG_W-1:0]               o_energy_sum,
    output logic [scpfa_pkg::OVL_W-1:0]               o_overlap_count,
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [scpfa_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [scpfa_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import scpfa_pkg::*;

    t_cfg                   cfg;
    t_pair                  q_in, q_out;
    logic                   q_push, q_full, q_pop, q_empty;
    logic [2:0][FRC_W-1:0]  force_w;

    scpfa_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    scpfa_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_push        (push),
        .i_ref         ({i_ref_z, i_ref_y, i_ref_x}),
        .i_other       ({i_other_z, i_other_y, i_other_x}),
        .i_pair_counts (i_pair_counts),
        .i_last_pair   (i_last_pair),
        .o_full        (full),
        .i_q_full      (q_full),
        .o_q_push      (q_push),
        .o_q_data      (q_in)
    );

    scpfa_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_out)
    );

    scpfa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_q_empty (q_empty),
        .i_q_data  (q_out),
        .o_q_pop   (q_pop),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_force   (force_w),
        .o_energy  (o_energy_sum),
        .o_overlap (o_overlap_count)
    );

    assign o_force_x = force_w[0];
    assign o_force_y = force_w[1];
    assign o_force_z = force_w[2];

endmodule
`default_nettype wire
